[hw/rtl/rtr_pkg.sv]
// ----------------------------------------------------------------------------
// rtr_pkg
// types and constants shared by the reply token recognizer
// ----------------------------------------------------------------------------
package rtr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 3;
  localparam int unsigned PosW  = 4;

  typedef enum logic [PosW-1:0] {
    POS_IDLE = 4'd0,
    POS_C    = 4'd1,
    POS_CM   = 4'd2,
    POS_A    = 4'd3,
    POS_AO   = 4'd4,
    POS_CO   = 4'd5,
    POS_CON  = 4'd6,
    POS_E    = 4'd7,
    POS_EN   = 4'd8,
    POS_CR   = 4'd9,
    POS_LF   = 4'd10
  } pos_t;

  typedef enum logic [CodeW-1:0] {
    CODE_NONE = 3'd0,
    CODE_CMD  = 3'd1,
    CODE_AOK  = 3'd2,
    CODE_CONN = 3'd3,
    CODE_END  = 3'd4
  } code_t;

  localparam logic [ByteW-1:0] ChC  = 8'h43;
  localparam logic [ByteW-1:0] ChA  = 8'h41;
  localparam logic [ByteW-1:0] ChE  = 8'h45;
  localparam logic [ByteW-1:0] ChM  = 8'h4d;
  localparam logic [ByteW-1:0] ChO  = 8'h4f;
  localparam logic [ByteW-1:0] ChD  = 8'h44;
  localparam logic [ByteW-1:0] ChK  = 8'h4b;
  localparam logic [ByteW-1:0] ChN  = 8'h4e;
  localparam logic [ByteW-1:0] ChCr = 8'd13;
  localparam logic [ByteW-1:0] ChLf = 8'd10;

  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [CodeW-1:0] pending;
  } parse_state_t;

  typedef struct packed {
    logic             line_end;
    logic [CodeW-1:0] code;
    logic             done;
  } result_t;

endpackage

[hw/rtl/rtr_parser.sv]
// ----------------------------------------------------------------------------
// rtr_parser
// one-byte step of the reply parser: next state and result for a word
// ----------------------------------------------------------------------------
module rtr_parser
  import rtr_pkg::*;
(
  input  logic [ByteW-1:0] rx_byte,
  input  logic             command_mode,
  input  parse_state_t     cur,
  output parse_state_t     nxt,
  output result_t          res
);

  always_comb begin
    nxt = cur;
    res = '0;
    if (command_mode) begin
      nxt.pos = POS_IDLE;
      case (cur.pos)
        POS_IDLE: begin
          nxt.pending = CODE_NONE;
          if (rx_byte == ChC) nxt.pos = POS_C;
          else if (rx_byte == ChA) nxt.pos = POS_A;
          else if (rx_byte == ChE) nxt.pos = POS_E;
        end
        POS_C: begin
          if (rx_byte == ChM) nxt.pos = POS_CM;
          else if (rx_byte == ChO) nxt.pos = POS_CO;
        end
        POS_CM: begin
          if (rx_byte == ChD) begin
            nxt.pending = CODE_CMD;
            nxt.pos     = POS_CR;
          end
        end
        POS_A: begin
          if (rx_byte == ChO) nxt.pos = POS_AO;
        end
        POS_AO: begin
          if (rx_byte == ChK) begin
            nxt.pending = CODE_AOK;
            nxt.pos     = POS_CR;
          end
        end
        POS_CO: begin
          if (rx_byte == ChN) nxt.pos = POS_CON;
        end
        POS_CON: begin
          if (rx_byte == ChN) begin
            nxt.pending = CODE_CONN;
            res.done    = 1'b1;
            res.code    = CODE_CONN;
          end
        end
        POS_E: begin
          if (rx_byte == ChN) nxt.pos = POS_EN;
        end
        POS_EN: begin
          if (rx_byte == ChD) begin
            nxt.pending = CODE_END;
            nxt.pos     = POS_CR;
          end
        end
        POS_CR: begin
          if (rx_byte == ChCr) nxt.pos = POS_LF;
        end
        POS_LF: begin
          if (rx_byte == ChLf) begin
            res.done = 1'b1;
            res.code = cur.pending;
          end
        end
        default: begin
          nxt.pos = POS_IDLE;
        end
      endcase
    end else begin
      res.line_end = (rx_byte == ChCr);
    end
  end

endmodule

[hw/rtl/module_response_token_recognizer_core.sv]
// ----------------------------------------------------------------------------
// module_response_token_recognizer_core
// recognizes CMD, AOK, END and CONN replies on a received byte stream
// ----------------------------------------------------------------------------
// each accepted input word yields one registered result word on out_tdata
// throughput: 1 word per cycle while the output is not stalled, set by the single parser state register
// the output register takes a new word whenever it is empty or being drained
// reset: synchronous active-low rst_n clears parser state, mode and out_tvalid
// ----------------------------------------------------------------------------
module module_response_token_recognizer_core
  import rtr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // command_mode
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata      // [0] reply_done, [3:1] reply_code, [4] line_end
);

  logic         mode_r;
  parse_state_t state_r, state_nxt;
  result_t      res_nxt, res_r;
  logic         out_valid_r;
  logic         accept;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  rtr_parser u_parser (
    .rx_byte      (in_tdata),
    .command_mode (mode_r),
    .cur          (state_r),
    .nxt          (state_nxt),
    .res          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      state_r     <= '{pos: POS_IDLE, pending: CODE_NONE};
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      if (accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r};

endmodule

[hw/rtl/rtr_checker.sv]
// ----------------------------------------------------------------------------
// rtr_checker
// port-level checks for the reply token recognizer
// ----------------------------------------------------------------------------
module rtr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out word changed while stalled");

  // no code without completion pulse
  a_code_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[3:1] == 3'd0)
    else $error("reply code without done");

  // line end only in data mode, never with a completed reply
  a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> !out_tdata[0])
    else $error("line end with reply done");

  // a result appears only after an accepted word
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !(in_tvalid && in_tready) |=> !out_tvalid)
    else $error("result word without input word");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid after reset");

endmodule

bind module_response_token_recognizer_core rtr_checker u_rtr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// checks the reply token recognizer word by word against a local predictor
// ----------------------------------------------------------------------------
// a directed table covers data mode after reset, byte extremes, every reply
// and a mode change in the middle of a reply. Random phases of reply-shaped
// byte sequences follow, some of them corrupted, with noise bytes, random
// stalls on both sides, one long receiver hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  import rtr_pkg::*;

  localparam int unsigned PhaseWords = 150;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned RxHoldLen  = 300;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned MaxPrinted = 40;

  typedef struct packed {
    logic  done;
    code_t code;
    logic  line_end;
  } reply_t;

  typedef struct packed {
    logic       set_mode;
    logic       mode;
    logic [7:0] data;
    logic       typed;
    logic       done;
    code_t      code;
    logic       line_end;
  } dir_row_t;

  // set_mode, mode, byte, typed, done, code, line_end
  localparam dir_row_t DirRows [23] = '{
    '{1'b0, 1'b0, ChCr,  1'b1, 1'b0, CODE_NONE, 1'b1},
    '{1'b0, 1'b0, 8'h00, 1'b1, 1'b0, CODE_NONE, 1'b0},
    '{1'b0, 1'b0, 8'hff, 1'b1, 1'b0, CODE_NONE, 1'b0},
    '{1'b1, 1'b1, ChC,   1'b0, 1'b0, CODE_NONE, 1'b0},
    '{1'b0, 1'b0, ChM,   1'b0, 1'b0, CODE_NONE, 1'b0},
    '{1'b0, 1'b0, ChD,   1'b0, 1'b0, CODE_NONE, 1'b0},
    '{1'b0, 1'b0, ChCr,  1'b0, 1'b0, CODE_NONE, 1'b0},
    '{1'b0, 1'b0, ChLf,  1'b1, 1'b1, CODE_CMD,  1'b0},
    '{1'b0, 1'b0, ChC,   1'b0, 1'b0, CODE_NONE, 1'b0},
    '{1'b0, 1'b0, ChO,   1'b0, 1'b0, CODE_NONE, 1'b0},
    '{1'b0, 1'b0, ChN,   1'b0, 1'b0, CODE_NONE, 1'b0},
    '{1'b0, 1'b0, ChN,   1'b1, 1'b1, CODE_CONN, 1'b0},
    '{1'b0, 1'b0, ChE,   1'b0, 1'b0, CODE_NONE, 1'b0},
    '{1'b0, 1'b0, ChN,   1'b0, 1'b0, CODE_NONE, 1'b0},
    '{1'b0, 1'b0, ChD,   1'b0, 1'b0, CODE_NONE, 1'b0},
    '{1'b0, 1'b0, ChCr,  1'b0, 1'b0, CODE_NONE, 1'b0},
    '{1'b0, 1'b0, ChLf,  1'b1, 1'b1, CODE_END,  1'b0},
    '{1'b0, 1'b0, ChA,   1'b0, 1'b0, CODE_NONE, 1'b0},
    '{1'b0, 1'b0, ChO,   1'b0, 1'b0, CODE_NONE, 1'b0},
    '{1'b1, 1'b0, ChCr,  1'b1, 1'b0, CODE_NONE, 1'b1},
    '{1'b1, 1'b1, ChK,   1'b0, 1'b0, CODE_NONE, 1'b0},
    '{1'b0, 1'b0, ChCr,  1'b0, 1'b0, CODE_NONE, 1'b0},
    '{1'b0, 1'b0, ChLf,  1'b1, 1'b1, CODE_AOK,  1'b0}
  };

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_wr_en   = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_tvalid   = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata    = 8'h00;
  logic       out_tvalid;
  logic       out_tready  = 1'b0;
  logic [7:0] out_tdata;

  // predictor state
  logic  trk_mode    = 1'b0;
  pos_t  trk_pos     = POS_IDLE;
  code_t trk_pending = CODE_NONE;

  reply_t      expected_replies[$];
  logic [7:0]  frag_q[$];
  int unsigned errors      = 0;
  int unsigned idle_cycles = 0;
  logic        tx_idle_on  = 1'b1;
  logic        rx_stall_on = 1'b1;
  logic        rx_hold_req = 1'b0;

  module_response_token_recognizer_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),      // [7:0] rx_byte
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)      // [0] reply_done, [3:1] reply_code, [4] line_end
  );

  always #2 clk = ~clk;

  function automatic reply_t recognize_byte(input logic [7:0] b);
    reply_t r;
    pos_t   nxt;
    r.done     = 1'b0;
    r.code     = CODE_NONE;
    r.line_end = 1'b0;
    if (!trk_mode) begin
      r.line_end = (b == ChCr);
      return r;
    end
    nxt = POS_IDLE;
    case (trk_pos)
      POS_IDLE: begin
        trk_pending = CODE_NONE;
        if (b == ChC) nxt = POS_C;
        else if (b == ChA) nxt = POS_A;
        else if (b == ChE) nxt = POS_E;
      end
      POS_C: begin
        if (b == ChM) nxt = POS_CM;
        else if (b == ChO) nxt = POS_CO;
      end
      POS_CM: if (b == ChD) begin
        trk_pending = CODE_CMD;
        nxt = POS_CR;
      end
      POS_A: if (b == ChO) nxt = POS_AO;
      POS_AO: if (b == ChK) begin
        trk_pending = CODE_AOK;
        nxt = POS_CR;
      end
      POS_CO: if (b == ChN) nxt = POS_CON;
      POS_CON: if (b == ChN) begin
        trk_pending = CODE_CONN;
        r.done = 1'b1;
        r.code = CODE_CONN;
      end
      POS_E: if (b == ChN) nxt = POS_EN;
      POS_EN: if (b == ChD) begin
        trk_pending = CODE_END;
        nxt = POS_CR;
      end
      POS_CR: if (b == ChCr) nxt = POS_LF;
      POS_LF: if (b == ChLf) begin
        r.done = 1'b1;
        r.code = trk_pending;
      end
      default: ;
    endcase
    trk_pos = nxt;
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(3, 1);
    else return $urandom_range(40, 4);
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(19))
      0: return ChC;
      1: return ChA;
      2: return ChE;
      3: return ChM;
      4: return ChO;
      5: return ChD;
      6: return ChK;
      7: return ChN;
      8: return ChCr;
      9: return ChLf;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one reply-shaped sequence, sometimes corrupted, or a short run of noise
  function automatic void fill_fragment();
    int unsigned kind;
    int unsigned at;
    frag_q.delete();
    kind = $urandom_range(9);
    case (kind)
      0, 1: frag_q = '{ChC, ChM, ChD, ChCr, ChLf};
      2, 3: frag_q = '{ChA, ChO, ChK, ChCr, ChLf};
      4, 5: frag_q = '{ChE, ChN, ChD, ChCr, ChLf};
      6, 7: frag_q = '{ChC, ChO, ChN, ChN};
      default: repeat ($urandom_range(4, 1)) frag_q.push_back(noise_byte());
    endcase
    if (kind < 8 && $urandom_range(4) == 0) begin
      at = $urandom_range(frag_q.size() - 1);
      frag_q[at] = noise_byte();
    end
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MaxPrinted) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic send_byte(input logic [7:0] b, output reply_t predicted);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    predicted = recognize_byte(b);
  endtask

  task automatic sender_gap();
    int unsigned n;
    n = (tx_idle_on && !rx_hold_req) ? idle_len() : 0;
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    trk_mode = m;
  endtask

  // receiver side
  initial begin
    int unsigned n;
    forever begin
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (RxHoldLen) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        n = rx_stall_on ? idle_len() : 0;
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    reply_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", out_tdata));
      end else begin
        e = expected_replies.pop_front();
        if (out_tdata[0] !== e.done)
          report_mismatch($sformatf("reply_done %b want %b", out_tdata[0], e.done));
        if (out_tdata[3:1] !== e.code)
          report_mismatch($sformatf("reply_code %0d want %0d", out_tdata[3:1], e.code));
        if (out_tdata[4] !== e.line_end)
          report_mismatch($sformatf("line_end %b want %b", out_tdata[4], e.line_end));
        if (out_tdata[7:5] !== 3'b000)
          report_mismatch($sformatf("padding bits %b not zero", out_tdata[7:5]));
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reply_t      got;
    reply_t      want;
    int unsigned sent;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DirRows[i]) begin
      if (DirRows[i].set_mode) write_mode(DirRows[i].mode);
      send_byte(DirRows[i].data, got);
      if (DirRows[i].typed) begin
        want.done     = DirRows[i].done;
        want.code     = DirRows[i].code;
        want.line_end = DirRows[i].line_end;
        expected_replies.push_back(want);
      end else begin
        expected_replies.push_back(got);
      end
      sender_gap();
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_mode((ph % 3 == 1) ? 1'b0 : 1'b1);
      tx_idle_on  = (ph != 2);
      rx_stall_on = (ph != 2);
      sent = 0;
      while (sent < PhaseWords) begin
        fill_fragment();
        // a phase may end mid-reply so the next mode change lands inside one
        for (int k = 0; k < frag_q.size() && sent < PhaseWords; k++) begin
          if (ph == 3 && sent == 20) rx_hold_req = 1'b1;
          if (ph == 5 && sent == 75) drain();
          send_byte(frag_q[k], got);
          expected_replies.push_back(got);
          sent++;
          sender_gap();
        end
      end
    end

    in_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/rtr_pkg.sv
hw/rtl/rtr_parser.sv
hw/rtl/module_response_token_recognizer_core.sv
hw/rtl/rtr_checker.sv
dv/tb_top.sv
